// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/m3inv_pkg.sv =====
// package for the 3x3 matrix inverse unit: widths, types, tables, saturation
package m3inv_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ELEM_WIDTH = 32;
   localparam int NUM_ELEMS  = 9;
   localparam int NUM_PRODS  = 2 * NUM_ELEMS;
   localparam int NUM_ROW    = 3;

   localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
   localparam int COF_WIDTH  = PROD_WIDTH + 1;
   localparam int PP_WIDTH   = 2 * ELEM_WIDTH + 1;
   localparam int DET_WIDTH  = 3 * ELEM_WIDTH + 3;
   localparam int NUM_WIDTH  = COF_WIDTH + 2 * FRAC_BITS;
   localparam int SDEN_WIDTH = DET_WIDTH + ELEM_WIDTH;
   localparam int EXT_WIDTH  = ((NUM_WIDTH > SDEN_WIDTH) ? NUM_WIDTH : SDEN_WIDTH) + 1;
   localparam int REM_WIDTH  = DET_WIDTH + 1;
   localparam int DOUT_WIDTH = DET_WIDTH - 2 * FRAC_BITS;

   localparam int DIV_STAGE  = 7;
   localparam int LATENCY    = ELEM_WIDTH + 10;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [COF_WIDTH-1:0]  cof_type;
   typedef logic signed [PP_WIDTH-1:0]   pp_type;
   typedef logic signed [DET_WIDTH-1:0]  det_type;
   typedef logic [DET_WIDTH-1:0]         dmag_type;
   typedef logic [COF_WIDTH-1:0]         nmag_type;
   typedef logic [EXT_WIDTH-1:0]         ext_type;
   typedef logic [REM_WIDTH-1:0]         rem_type;
   typedef logic [ELEM_WIDTH-1:0]        quo_type;
   typedef logic [ELEM_WIDTH:0]          qrnd_type;
   typedef logic [3:0]                   idx_type;

   // cofactor k = a[P]*a[Q] - a[S]*a[T]
   localparam idx_type COF_P [NUM_ELEMS] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam idx_type COF_Q [NUM_ELEMS] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam idx_type COF_S [NUM_ELEMS] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam idx_type COF_T [NUM_ELEMS] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
   // first-row expansion uses these cofactors
   localparam idx_type DET_COF [NUM_ROW] = '{4'd0, 4'd3, 4'd6};

   function automatic elem_type sat_q(input qrnd_type q, input logic neg, input logic ovf);
      qrnd_type lim;
      qrnd_type mag;
      qrnd_type res;
      lim = qrnd_type'(1) << (ELEM_WIDTH - 1);
      if (!neg) begin
         lim = lim - qrnd_type'(1);
      end
      mag = (ovf || (q > lim)) ? lim : q;
      res = neg ? (~mag + qrnd_type'(1)) : mag;
      return elem_type'(res[ELEM_WIDTH-1:0]);
   endfunction

endpackage

// ===== hw/rtl/mat3_inverse_unit.sv =====
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
`include "assert_macros.svh"
// Takes one matrix per cycle and never stalls: busy is low except during reset.
// Each result appears on the rsp_ ports for one cycle with rsp_valid, in order;
// the receiver must take it then. The latency is set by the nine parallel
// restoring dividers, which resolve one quotient bit per stage, behind seven
// stages of products, cofactors, determinant and magnitudes.
module mat3_inverse_unit import m3inv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  elem_type req_m00,
   input  elem_type req_m01,
   input  elem_type req_m02,
   input  elem_type req_m10,
   input  elem_type req_m11,
   input  elem_type req_m12,
   input  elem_type req_m20,
   input  elem_type req_m21,
   input  elem_type req_m22,
   output logic     rsp_valid,
   output elem_type rsp_r00,
   output elem_type rsp_r01,
   output elem_type rsp_r02,
   output elem_type rsp_r10,
   output elem_type rsp_r11,
   output elem_type rsp_r12,
   output elem_type rsp_r20,
   output elem_type rsp_r21,
   output elem_type rsp_r22,
   output elem_type rsp_determinant,
   output logic     rsp_singular
);

   logic                 req_fire;
   logic [LATENCY-1:0]   valid_ff;
   logic [LATENCY-1:0]   valid_in;
   elem_type             elem_in [NUM_ELEMS];

   elem_type elem_ff [NUM_ELEMS];
   prod_type prod_ff [NUM_PRODS];
   elem_type row1_ff [NUM_ROW];
   cof_type  cof2_ff [NUM_ELEMS];
   elem_type row2_ff [NUM_ROW];
   pp_type   pplo_ff [NUM_ROW];
   pp_type   pphi_ff [NUM_ROW];
   cof_type  cof3_ff [NUM_ELEMS];
   det_type  term_ff [NUM_ROW];
   cof_type  cof4_ff [NUM_ELEMS];
   det_type  det_ff;
   cof_type  cof5_ff [NUM_ELEMS];
   dmag_type dmag_ff;
   logic     dneg_ff;
   logic     dzero_ff;
   nmag_type nmag_ff [NUM_ELEMS];
   logic     nneg_ff [NUM_ELEMS];

   dmag_type den_ff  [ELEM_WIDTH+1];
   logic     zero_ff [ELEM_WIDTH+1];
   elem_type dout_ff [ELEM_WIDTH+1];
   rem_type  rem_ff  [ELEM_WIDTH+1][NUM_ELEMS];
   quo_type  low_ff  [ELEM_WIDTH+1][NUM_ELEMS];
   logic     ovf_ff  [ELEM_WIDTH+1][NUM_ELEMS];
   logic     sgn_ff  [ELEM_WIDTH+1][NUM_ELEMS];
   rem_type  rem_in  [1:ELEM_WIDTH][NUM_ELEMS];
   quo_type  low_in  [1:ELEM_WIDTH][NUM_ELEMS];

   qrnd_type qr_ff    [NUM_ELEMS];
   logic     rovf_ff  [NUM_ELEMS];
   logic     rsgn_ff  [NUM_ELEMS];
   logic     rzero_ff;
   elem_type rdout_ff;

   elem_type res_ff [NUM_ELEMS];
   elem_type det_out_ff;
   logic     sing_ff;

   assign busy     = reset;
   assign req_fire = start && !busy;
   assign valid_in = {valid_ff[LATENCY-2:0], req_fire};

   assign elem_in[0] = req_m00;
   assign elem_in[1] = req_m01;
   assign elem_in[2] = req_m02;
   assign elem_in[3] = req_m10;
   assign elem_in[4] = req_m11;
   assign elem_in[5] = req_m12;
   assign elem_in[6] = req_m20;
   assign elem_in[7] = req_m21;
   assign elem_in[8] = req_m22;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // products, cofactors, determinant, magnitudes
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
         elem_ff[i]           <= elem_in[i];
         prod_ff[2*i]         <= elem_ff[COF_P[i]] * elem_ff[COF_Q[i]];
         prod_ff[2*i+1]       <= elem_ff[COF_S[i]] * elem_ff[COF_T[i]];
         cof2_ff[i]           <= cof_type'(prod_ff[2*i]) - cof_type'(prod_ff[2*i+1]);
         cof3_ff[i]           <= cof2_ff[i];
         cof4_ff[i]           <= cof3_ff[i];
         cof5_ff[i]           <= cof4_ff[i];
         nmag_ff[i]           <= cof5_ff[i][COF_WIDTH-1] ? nmag_type'(-cof5_ff[i])
                                                          : nmag_type'(cof5_ff[i]);
         nneg_ff[i]           <= cof5_ff[i][COF_WIDTH-1] ^ det_ff[DET_WIDTH-1];
      end
      for (int j = 0; j < NUM_ROW; j++) begin
         row1_ff[j] <= elem_ff[j];
         row2_ff[j] <= row1_ff[j];
         pplo_ff[j] <= row2_ff[j] * $signed({1'b0, cof2_ff[DET_COF[j]][ELEM_WIDTH-1:0]});
         pphi_ff[j] <= row2_ff[j] * $signed(cof2_ff[DET_COF[j]][COF_WIDTH-1:ELEM_WIDTH]);
         term_ff[j] <= (det_type'(pphi_ff[j]) <<< ELEM_WIDTH) + det_type'(pplo_ff[j]);
      end
      det_ff   <= term_ff[0] + term_ff[1] + term_ff[2];
      dmag_ff  <= det_ff[DET_WIDTH-1] ? dmag_type'(-det_ff) : dmag_type'(det_ff);
      dneg_ff  <= det_ff[DET_WIDTH-1];
      dzero_ff <= (det_ff == '0);
   end

   // divider setup: overflow check, first partial remainder, determinant field
   always_ff @(posedge clock) begin
      logic [DOUT_WIDTH:0] dq;
      ext_type             num;
      ext_type             sden;
      dq = {1'b0, dmag_ff[DET_WIDTH-1:2*FRAC_BITS]} + (DOUT_WIDTH+1)'(dmag_ff[2*FRAC_BITS-1]);
      sden = ext_type'({dmag_ff, {ELEM_WIDTH{1'b0}}});
      den_ff[0]  <= dmag_ff;
      zero_ff[0] <= dzero_ff;
      dout_ff[0] <= sat_q(dq[ELEM_WIDTH:0], dneg_ff, |dq[DOUT_WIDTH:ELEM_WIDTH+1]);
      for (int i = 0; i < NUM_ELEMS; i++) begin
         num = ext_type'({nmag_ff[i], {(2*FRAC_BITS){1'b0}}});
         ovf_ff[0][i] <= (num >= sden);
         rem_ff[0][i] <= num[ELEM_WIDTH +: REM_WIDTH];
         low_ff[0][i] <= num[ELEM_WIDTH-1:0];
         sgn_ff[0][i] <= nneg_ff[i];
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= ELEM_WIDTH; k++) begin : g_div
      always_comb begin
         rem_type trial;
         for (int i = 0; i < NUM_ELEMS; i++) begin
            trial = {rem_ff[k-1][i][REM_WIDTH-2:0], low_ff[k-1][i][ELEM_WIDTH-1]};
            if (trial >= {1'b0, den_ff[k-1]}) begin
               rem_in[k][i] = trial - {1'b0, den_ff[k-1]};
               low_in[k][i] = {low_ff[k-1][i][ELEM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in[k][i] = trial;
               low_in[k][i] = {low_ff[k-1][i][ELEM_WIDTH-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         den_ff[k]  <= den_ff[k-1];
         zero_ff[k] <= zero_ff[k-1];
         dout_ff[k] <= dout_ff[k-1];
         for (int i = 0; i < NUM_ELEMS; i++) begin
            rem_ff[k][i] <= rem_in[k][i];
            low_ff[k][i] <= low_in[k][i];
            ovf_ff[k][i] <= ovf_ff[k-1][i];
            sgn_ff[k][i] <= sgn_ff[k-1][i];
         end
      end
   end

   // round half away from zero
   always_ff @(posedge clock) begin
      rzero_ff <= zero_ff[ELEM_WIDTH];
      rdout_ff <= dout_ff[ELEM_WIDTH];
      for (int i = 0; i < NUM_ELEMS; i++) begin
         qr_ff[i] <= {1'b0, low_ff[ELEM_WIDTH][i]}
                     + qrnd_type'({rem_ff[ELEM_WIDTH][i][REM_WIDTH-2:0], 1'b0}
                                  >= {1'b0, den_ff[ELEM_WIDTH]});
         rovf_ff[i] <= ovf_ff[ELEM_WIDTH][i];
         rsgn_ff[i] <= sgn_ff[ELEM_WIDTH][i];
      end
   end

   // saturate, sign, singular override
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
         res_ff[i] <= rzero_ff ? '0 : sat_q(qr_ff[i], rsgn_ff[i], rovf_ff[i]);
      end
      det_out_ff <= rzero_ff ? '0 : rdout_ff;
      sing_ff    <= rzero_ff;
   end

   assign rsp_valid       = valid_ff[LATENCY-1];
   assign rsp_r00         = res_ff[0];
   assign rsp_r01         = res_ff[1];
   assign rsp_r02         = res_ff[2];
   assign rsp_r10         = res_ff[3];
   assign rsp_r11         = res_ff[4];
   assign rsp_r12         = res_ff[5];
   assign rsp_r20         = res_ff[6];
   assign rsp_r21         = res_ff[7];
   assign rsp_r22         = res_ff[8];
   assign rsp_determinant = det_out_ff;
   assign rsp_singular    = sing_ff;

   `ASSERT_NEXT(a_latency, 1'b1, valid_ff[LATENCY-1:1] == $past(valid_ff[LATENCY-2:0]))
   `ASSERT_NEXT(a_enter, req_fire, valid_ff[0])
   `ASSERT_IMPLY(a_rem_below_den, valid_ff[DIV_STAGE] && !ovf_ff[0][0], rem_ff[0][0] < {1'b0, den_ff[0]})
   `ASSERT_IMPLY(a_singular_zero, rsp_valid && rsp_singular, rsp_determinant == '0 && rsp_r00 == '0 && rsp_r11 == '0 && rsp_r22 == '0)

endmodule

// ===== tb/tb_top.sv =====
// testbench for the 3x3 matrix inverse unit: directed and random matrices against a wide-integer model
module tb_top;
   import m3inv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;
   typedef struct {
      elem_type inv [9];
      elem_type det;
      logic     sing;
   } inverse_type;

   logic     clock = 0;
   logic     reset = 1;
   logic     start = 0;
   logic     busy;
   elem_type mat [9];
   logic     rsp_valid;
   elem_type rsp_r [9];
   elem_type rsp_determinant;
   logic     rsp_singular;

   inverse_type expected_q [$];
   int       cycles = 0;
   int       errors = 0;
   int       beats_in = 0;
   int       beats_out = 0;
   int       singular_seen = 0;

   initial for (int k = 0; k < 9; k++) mat[k] = '0;

   always #1 clock = ~clock;

   mat3_inverse_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(mat[0]), .req_m01(mat[1]), .req_m02(mat[2]),
      .req_m10(mat[3]), .req_m11(mat[4]), .req_m12(mat[5]),
      .req_m20(mat[6]), .req_m21(mat[7]), .req_m22(mat[8]),
      .rsp_valid(rsp_valid),
      .rsp_r00(rsp_r[0]), .rsp_r01(rsp_r[1]), .rsp_r02(rsp_r[2]),
      .rsp_r10(rsp_r[3]), .rsp_r11(rsp_r[4]), .rsp_r12(rsp_r[5]),
      .rsp_r20(rsp_r[6]), .rsp_r21(rsp_r[7]), .rsp_r22(rsp_r[8]),
      .rsp_determinant(rsp_determinant), .rsp_singular(rsp_singular)
   );

   // num * 2^sh / den, rounded half away from zero, saturated
   function automatic elem_type round_quot(input wide_type num, input int sh,
                                           input wide_type den);
      logic     neg;
      wide_type n;
      wide_type d;
      wide_type q;
      wide_type r;
      wide_type lim;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      n = n <<< sh;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      if ((r <<< 1) >= d) q = q + 1;
      lim = neg ? (wide_type'(1) <<< 31) : ((wide_type'(1) <<< 31) - 1);
      if (q > lim) q = lim;
      if (neg) q = -q;
      return elem_type'(q[31:0]);
   endfunction

   function automatic inverse_type invert(input elem_type m [9]);
      wide_type    a [9];
      wide_type    c [9];
      wide_type    det;
      inverse_type res;
      for (int k = 0; k < 9; k++) a[k] = m[k];
      c[0] = a[4]*a[8] - a[5]*a[7];
      c[1] = a[2]*a[7] - a[1]*a[8];
      c[2] = a[1]*a[5] - a[2]*a[4];
      c[3] = a[5]*a[6] - a[3]*a[8];
      c[4] = a[0]*a[8] - a[2]*a[6];
      c[5] = a[2]*a[3] - a[0]*a[5];
      c[6] = a[3]*a[7] - a[4]*a[6];
      c[7] = a[1]*a[6] - a[0]*a[7];
      c[8] = a[0]*a[4] - a[1]*a[3];
      det = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
      if (det == 0) begin
         for (int k = 0; k < 9; k++) res.inv[k] = '0;
         res.det = '0;
         res.sing = 1'b1;
      end else begin
         for (int k = 0; k < 9; k++) res.inv[k] = round_quot(c[k], 32, det);
         res.det = round_quot(det, 0, wide_type'(1) <<< 32);
         res.sing = 1'b0;
      end
      return res;
   endfunction

   // accepted input beats
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_q.push_back(invert(mat));
         beats_in++;
      end
   end

   // result checker
   always @(posedge clock) begin
      inverse_type e;
      cycles++;
      if (!reset && rsp_valid) begin
         beats_out++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat", $time);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (e.sing) singular_seen++;
            for (int k = 0; k < 9; k++)
               if (rsp_r[k] !== e.inv[k]) begin
                  $display("%0t: r%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                           e.inv[k], rsp_r[k]);
                  errors++;
               end
            if (rsp_determinant !== e.det) begin
               $display("%0t: determinant expected %h actual %h", $time, e.det,
                        rsp_determinant);
               errors++;
            end
            if (rsp_singular !== e.sing) begin
               $display("%0t: singular expected %b actual %b", $time, e.sing, rsp_singular);
               errors++;
            end
         end
      end
      if (cycles > 200000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_matrix(input elem_type m [9]);
      start <= 1'b1;
      for (int k = 0; k < 9; k++) mat[k] <= m[k];
      do @(posedge clock); while (!(start && !busy));
   endtask

   task automatic idle(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic elem_type q16(input int v);
      return elem_type'(v * 65536);
   endfunction

   task automatic test_directed();
      elem_type m [9];
      int       diag [6] = '{65536, 1, 32'h7fffffff, -32'sd2147483648, 2, 3 * 65536};
      foreach (diag[i]) begin
         m = '{diag[i], 0, 0, 0, diag[i], 0, 0, 0, diag[i]};
         send_matrix(m);
      end
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(m);
      m = '{q16(1), q16(2), q16(3), q16(4), q16(5), q16(6), q16(7), q16(8), q16(9)};
      send_matrix(m);
      for (int k = 0; k < 9; k++) m[k] = 32'h7fffffff;
      send_matrix(m);
      for (int k = 0; k < 9; k++) m[k] = 32'h80000000;
      send_matrix(m);
      m = '{32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 1,
            0, 1, 32'h80000000};
      send_matrix(m);
      m = '{q16(2), q16(1), 0, q16(1), q16(3), q16(1), 0, q16(1), q16(4)};
      send_matrix(m);
      m = '{q16(-2), 0, q16(1), 0, q16(5), 0, q16(1), 0, q16(-3)};
      send_matrix(m);
      m = '{q16(1), 1, 0, 0, q16(1), 0, 0, 0, 2};
      send_matrix(m);
      m = '{0, q16(1), 0, q16(1), 0, 0, 0, 0, q16(1)};
      send_matrix(m);
      m = '{3, 0, 0, 0, 3, 0, 0, 0, 3};
      send_matrix(m);
      idle(1);
   endtask

   task automatic test_random(input int count);
      elem_type m [9];
      int       sent = 0;
      int       burst;
      int       kind;
      int       row;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && sent < count; b++) begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++) begin
               case (kind)
                  0, 1, 2: m[k] = $urandom();
                  3, 4, 5: m[k] = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
                  6:       m[k] = (k % 4 == 0) ? $urandom() : 0;
                  default: m[k] = $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
               endcase
            end
            if (kind >= 8) begin
               // force a dependent row to get an exactly singular matrix
               row = $urandom_range(1, 2);
               for (int j = 0; j < 3; j++)
                  m[3 * row + j] = (kind == 8) ? m[j] : -m[j];
            end
            send_matrix(m);
            sent++;
         end
         if (sent < 150 || sent > 300) idle($urandom_range(0, 6));
      end
      idle(1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d matrices, checked %0d results, %0d of them singular",
               beats_in, beats_out, singular_seen);
      $display("covered identity, extremes, saturation, tiny and singular determinants");
      if (errors == 0 && beats_in == beats_out) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/m3inv_pkg.sv
hw/rtl/mat3_inverse_unit.sv
tb/tb_top.sv
